FILE: design/cbd_pkg.sv
`timescale 1ns / 1ps

package cbd_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int DATA_W    = 8;
	localparam int FUNC_W    = 2;
	localparam int STAT_W    = 2;
	localparam int CNT_W     = 7;

	localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_PEEK = 2'd2;

	localparam logic SIDE_LEFT  = 1'b0;
	localparam logic SIDE_RIGHT = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              side;
		logic [DATA_W-1:0] data_in;
	} cbd_in_t;

	typedef struct packed {
		logic [DATA_W-1:0] data_out;
		logic [STAT_W-1:0] status;
		logic [CNT_W-1:0]  count_out;
	} cbd_out_t;

	typedef struct packed {
		logic              valid;
		logic              hit;
		logic [STAT_W-1:0] status;
	} cbd_rsp_t;

endpackage

FILE: design/circular_byte_deque.sv
`timescale 1ns / 1ps

// channel   signals              handshake
// request   start, busy, req     word taken when start && !busy
// result    done, rsp            word shown for one cycle while done is high
//
// One request word is taken each cycle; busy stays low.
// Its result word appears in the cycle after acceptance, set by the
// registered read port of the byte store.
// Reset clears both pointers and the count; store contents are undefined.
// The receiver cannot stall, so no result is ever held back.

module circular_byte_deque #(
	parameter int DEPTH = cbd_pkg::DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cbd_pkg::cbd_in_t  req,
	output logic              done,
	output cbd_pkg::cbd_out_t rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic                       accept, we, re;
	logic [AW-1:0]              waddr, raddr;
	logic [cbd_pkg::DATA_W-1:0] wdata, rdata;
	logic [CW-1:0]              count;
	cbd_pkg::cbd_rsp_t          ctl_rsp;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	cbd_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (req),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.re     (re),
		.raddr  (raddr),
		.rsp    (ctl_rsp),
		.count  (count)
	);

	cbd_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign done          = ctl_rsp.valid;
	assign rsp.data_out  = ctl_rsp.hit ? rdata : '0;
	assign rsp.status    = ctl_rsp.status;
	assign rsp.count_out = cbd_pkg::CNT_W'(count);

endmodule

FILE: design/cbd_store.sv
`timescale 1ns / 1ps

module cbd_store #(
	parameter int DEPTH = cbd_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [cbd_pkg::DATA_W-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [cbd_pkg::DATA_W-1:0] rdata
);

	logic [cbd_pkg::DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: design/cbd_ctrl.sv
`timescale 1ns / 1ps

module cbd_ctrl #(
	parameter int DEPTH = cbd_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  cbd_pkg::cbd_in_t           req,
	output logic                       we,
	output logic [AW-1:0]              waddr,
	output logic [cbd_pkg::DATA_W-1:0] wdata,
	output logic                       re,
	output logic [AW-1:0]              raddr,
	output cbd_pkg::cbd_rsp_t          rsp,
	output logic [CW-1:0]              count
);

	localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	logic [AW-1:0] front_q, back_q, front_d, back_d;
	logic [AW-1:0] front_dec, back_inc, front_inc, back_dec;
	logic [CW-1:0] count_q, count_d;
	logic          empty, full, is_push, is_pop, is_peek;
	cbd_pkg::cbd_rsp_t rsp_d, rsp_s1;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_FULL);
	assign is_push = (req.func == cbd_pkg::FUNC_PUSH);
	assign is_pop  = (req.func == cbd_pkg::FUNC_POP);
	assign is_peek = (req.func == cbd_pkg::FUNC_PEEK);

	assign front_inc = (front_q == PTR_LAST) ? '0 : front_q + AW'(1);
	assign front_dec = (front_q == '0) ? PTR_LAST : front_q - AW'(1);
	assign back_inc  = (back_q == PTR_LAST) ? '0 : back_q + AW'(1);
	assign back_dec  = (back_q == '0) ? PTR_LAST : back_q - AW'(1);

	always_comb begin
		front_d      = front_q;
		back_d       = back_q;
		count_d      = count_q;
		we           = 1'b0;
		waddr        = front_q;
		wdata        = req.data_in;
		re           = 1'b0;
		raddr        = (req.side == cbd_pkg::SIDE_RIGHT) ? back_q : front_q;
		rsp_d.valid  = accept;
		rsp_d.hit    = 1'b0;
		rsp_d.status = cbd_pkg::ST_OK;
		if (accept) begin
			if (is_push) begin
				if (full) begin
					rsp_d.status = cbd_pkg::ST_FULL;
				end else begin
					we      = 1'b1;
					count_d = count_q + CW'(1);
					if (req.side == cbd_pkg::SIDE_RIGHT) begin
						if (!empty) begin
							back_d = back_inc;
						end
						waddr = back_d;
					end else begin
						if (!empty) begin
							front_d = front_dec;
						end
						waddr = front_d;
					end
				end
			end else if (is_pop || is_peek) begin
				if (empty) begin
					rsp_d.status = cbd_pkg::ST_EMPTY;
				end else begin
					re        = 1'b1;
					rsp_d.hit = 1'b1;
					if (is_pop) begin
						count_d = count_q - CW'(1);
						if (count_q != CW'(1)) begin
							if (req.side == cbd_pkg::SIDE_RIGHT) begin
								back_d = back_dec;
							end else begin
								front_d = front_inc;
							end
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
			rsp_s1  <= '0;
		end else begin
			front_q <= front_d;
			back_q  <= back_d;
			count_q <= count_d;
			rsp_s1  <= rsp_d;
		end
	end

	assign rsp   = rsp_s1;
	assign count = count_q;

endmodule

FILE: design/cbd_checker.sv
`timescale 1ns / 1ps

module cbd_checker #(
	parameter int DEPTH = cbd_pkg::DEPTH_DEF
) (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input cbd_pkg::cbd_in_t  req,
	input logic              done,
	input cbd_pkg::cbd_out_t rsp
);

	localparam logic [cbd_pkg::CNT_W-1:0] CNT_FULL = cbd_pkg::CNT_W'(DEPTH);

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(start && !busy && arst_n))
		else $error("result strobe does not follow accepted word");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == cbd_pkg::ST_EMPTY |-> rsp.data_out == '0 && rsp.count_out == '0)
		else $error("empty status with data or nonzero count");

	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == cbd_pkg::ST_FULL |-> rsp.data_out == '0 && rsp.count_out == CNT_FULL)
		else $error("full status without full count");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.func == cbd_pkg::FUNC_PUSH ##1 done &&
		rsp.status == cbd_pkg::ST_OK |-> rsp.count_out != '0 && rsp.data_out == '0)
		else $error("accepted push left count at zero");

endmodule

bind circular_byte_deque cbd_checker #(.DEPTH(DEPTH)) u_cbd_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.rsp    (rsp)
);
